[hw/rtl/illd_pkg.sv]
// ----------------------------------------------------------------------------
// illd_pkg: shared definitions for the line/literal deframer
// Character codes, error codes and parameter defaults.
// ----------------------------------------------------------------------------
package illd_pkg;

  localparam int SIZE_WIDTH_DEF = 31;
  localparam int ERR_W          = 3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_BRACE  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_SIZE  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NEG_SIZE  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BARE_LF   = 3'd4;

endpackage

[hw/rtl/illd_if.sv]
// ----------------------------------------------------------------------------
// illd_if: valid/ready channels of the line/literal deframer
// One channel for received bytes, one for marked result beats.
// ----------------------------------------------------------------------------
interface illd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface illd_res_if;
  import illd_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       data_byte;
  logic             in_literal;
  logic             literal_opens;
  logic             line_done;
  logic [ERR_W-1:0] error_code;

  modport source (output valid, output data_byte, output in_literal,
                  output literal_opens, output line_done, output error_code,
                  input ready);
  modport sink   (input valid, input data_byte, input in_literal,
                  input literal_opens, input line_done, input error_code,
                  output ready);
endinterface

[hw/rtl/imap_line_literal_deframer.sv]
// ----------------------------------------------------------------------------
// imap_line_literal_deframer: response line and literal deframer
// Marks logical lines, literal openings and literal payload in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received byte per beat (valid/ready).
//   res : exactly one result beat per received byte, in order: the byte
//         itself plus in_literal, literal_opens, line_done and error_code.
//   An accepted rx beat is registered and shows on res in the next cycle.
//   Throughput is one byte per cycle while res is not stalled; the decision
//   for a byte is one pass through the line-tail compare and one size-digit
//   multiply-add, between the rx handshake and the result register.
//   The result register acts as the output stage: a new byte is taken in the
//   same cycle the pending result is taken, so a receiver that takes every
//   cycle never stalls the stream. While res is stalled, rx.ready drops and
//   the pending beat holds.
//   Reset (synchronous, active high) empties the result register and returns
//   to line mode with an empty line; no clearing pass is needed.
//   A size marker of the form {n} CR LF opens n literal bytes; sizes above
//   2^SIZE_WIDTH - 1 are rejected as bad size.
// ----------------------------------------------------------------------------
module imap_line_literal_deframer #(
  parameter int SIZE_WIDTH = illd_pkg::SIZE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  illd_rx_if.sink     rx,
  illd_res_if.source  res
);
  import illd_pkg::*;

  localparam int ACC_W = SIZE_WIDTH + 4;

  // Line and literal state
  logic                  literal_mode, literal_mode_next;
  logic [SIZE_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [SIZE_WIDTH-1:0] size_accum, size_accum_next;
  logic                  brace_seen, brace_seen_next;
  logic                  size_invalid, size_invalid_next;
  logic                  size_minus, size_minus_next;
  logic                  size_digits, size_digits_next;
  logic [15:0]           last_two, last_two_next;
  logic [1:0]            bytes_in_line, bytes_in_line_next;

  // Result register
  logic             res_valid;
  logic [7:0]       res_byte;
  logic             res_lit, res_lit_next;
  logic             res_opens, res_opens_next;
  logic             res_done, res_done_next;
  logic [ERR_W-1:0] res_err, res_err_next;

  logic       accept;
  logic [7:0] c;
  logic [7:0] prev, prev2;
  logic [ACC_W-1:0] acc_wide;
  logic [SIZE_WIDTH-1:0] bl_dec;

  // Take a byte whenever the result stage is empty or being drained.
  assign rx.ready = !res_valid || res.ready;
  assign accept   = rx.valid && rx.ready;
  assign c        = rx.rx_byte;
  assign prev     = last_two[7:0];
  assign prev2    = last_two[15:8];

  // size * 10 + digit, wide enough to see overflow past SIZE_WIDTH bits
  assign acc_wide = ({4'b0, size_accum} << 3) + ({4'b0, size_accum} << 1)
                  + {{(ACC_W-8){1'b0}}, prev2 - CH_ZERO};
  assign bl_dec   = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;

  always_comb begin
    literal_mode_next  = literal_mode;
    bytes_left_next    = bytes_left;
    size_accum_next    = size_accum;
    brace_seen_next    = brace_seen;
    size_invalid_next  = size_invalid;
    size_minus_next    = size_minus;
    size_digits_next   = size_digits;
    last_two_next      = last_two;
    bytes_in_line_next = bytes_in_line;
    res_lit_next       = 1'b0;
    res_opens_next     = 1'b0;
    res_done_next      = 1'b0;
    res_err_next       = ERR_NONE;

    if (literal_mode) begin
      // Literal payload: pass through, count down, leave line state alone.
      res_lit_next    = 1'b1;
      bytes_left_next = bl_dec;
      if (bl_dec == '0) begin
        literal_mode_next = 1'b0;
      end
    end else if (c == CH_LF) begin
      if (bytes_in_line != 2'd0 && prev == CH_CR) begin
        if (bytes_in_line == 2'd2 && prev2 == CH_CLOSE) begin
          // Size marker line: validate the scanned size.
          if (!brace_seen) begin
            res_err_next = ERR_NO_BRACE;
          end else if (size_invalid || !size_digits) begin
            res_err_next = ERR_BAD_SIZE;
          end else if (size_minus && size_accum != '0) begin
            res_err_next = ERR_NEG_SIZE;
          end else begin
            res_opens_next    = 1'b1;
            bytes_left_next   = size_accum;
            literal_mode_next = (size_accum != '0);
          end
        end else begin
          res_done_next = 1'b1;
        end
      end else begin
        res_err_next = ERR_BARE_LF;
      end
      if (res_err_next != ERR_NONE) begin
        literal_mode_next = 1'b0;
        bytes_left_next   = '0;
      end
      // Every LF in line mode starts a fresh segment.
      brace_seen_next    = 1'b0;
      size_accum_next    = '0;
      size_invalid_next  = 1'b0;
      size_minus_next    = 1'b0;
      size_digits_next   = 1'b0;
      last_two_next      = '0;
      bytes_in_line_next = 2'd0;
    end else begin
      // Scan the byte two places back, so a closing brace and CR never
      // enter the size scan.
      if (bytes_in_line == 2'd2) begin
        if (prev2 == CH_OPEN) begin
          brace_seen_next   = 1'b1;
          size_accum_next   = '0;
          size_invalid_next = 1'b0;
          size_minus_next   = 1'b0;
          size_digits_next  = 1'b0;
        end else if (brace_seen) begin
          if (prev2 >= CH_ZERO && prev2 <= CH_NINE) begin
            size_digits_next = 1'b1;
            if (acc_wide[ACC_W-1:SIZE_WIDTH] != '0) begin
              size_invalid_next = 1'b1;
            end else begin
              size_accum_next = acc_wide[SIZE_WIDTH-1:0];
            end
          end else if (prev2 == CH_MINUS && !size_minus && !size_digits) begin
            size_minus_next = 1'b1;
          end else begin
            size_invalid_next = 1'b1;
          end
        end
      end
      last_two_next = {prev, c};
      if (bytes_in_line != 2'd2) begin
        bytes_in_line_next = bytes_in_line + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      literal_mode  <= 1'b0;
      bytes_left    <= '0;
      size_accum    <= '0;
      brace_seen    <= 1'b0;
      size_invalid  <= 1'b0;
      size_minus    <= 1'b0;
      size_digits   <= 1'b0;
      last_two      <= '0;
      bytes_in_line <= 2'd0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        literal_mode  <= literal_mode_next;
        bytes_left    <= bytes_left_next;
        size_accum    <= size_accum_next;
        brace_seen    <= brace_seen_next;
        size_invalid  <= size_invalid_next;
        size_minus    <= size_minus_next;
        size_digits   <= size_digits_next;
        last_two      <= last_two_next;
        bytes_in_line <= bytes_in_line_next;
        res_valid     <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload of the result stage: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_byte  <= c;
      res_lit   <= res_lit_next;
      res_opens <= res_opens_next;
      res_done  <= res_done_next;
      res_err   <= res_err_next;
    end
  end

  assign res.valid         = res_valid;
  assign res.data_byte     = res_byte;
  assign res.in_literal    = res_lit;
  assign res.literal_opens = res_opens;
  assign res.line_done     = res_done;
  assign res.error_code    = res_err;

  // A literal in progress always has bytes left to pass.
  a_lit_count: assert property (@(posedge clk) disable iff (rst)
    literal_mode |-> bytes_left != '0)
    else $error("literal mode with no bytes left");

  // Size scan state stays clear until a brace opens it.
  a_scan_clear: assert property (@(posedge clk) disable iff (rst)
    !brace_seen |-> (size_accum == '0 && !size_digits && !size_minus && !size_invalid))
    else $error("size scan active without a brace");

  // A literal byte carries no line marks and no error.
  a_lit_marks: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.in_literal) |->
      (!res.line_done && !res.literal_opens && res.error_code == ERR_NONE))
    else $error("literal byte carries line marks");

  // Byte count of the line tail saturates at two.
  a_tail_count: assert property (@(posedge clk) disable iff (rst)
    bytes_in_line != 2'd3)
    else $error("line tail count overflow");

endmodule
